FILE: rtl/tesa_pkg.sv
// Package for the touch event sample assembler.
// Event codes, decoded op encoding, queue sizing and shared structs.
// No dependencies; imported by every module of the block.
package tesa_pkg;

  // Event types
  localparam logic [15:0] EVT_SYN = 16'h0000;
  localparam logic [15:0] EVT_KEY = 16'h0001;
  localparam logic [15:0] EVT_ABS = 16'h0003;

  // Key codes
  localparam logic [15:0] KEY_TOUCH = 16'h014a;
  localparam logic [15:0] KEY_LEFT  = 16'h0110;

  // Sync codes
  localparam logic [15:0] SYNC_REPORT    = 16'h0000;
  localparam logic [15:0] SYNC_MT_REPORT = 16'h0002;

  // Absolute axis codes
  localparam logic [15:0] AX_X           = 16'h0000;
  localparam logic [15:0] AX_Y           = 16'h0001;
  localparam logic [15:0] AX_PRESSURE    = 16'h0018;
  localparam logic [15:0] AX_TOUCH_MAJOR = 16'h0030;
  localparam logic [15:0] AX_MT_X        = 16'h0035;
  localparam logic [15:0] AX_MT_Y        = 16'h0036;
  localparam logic [15:0] AX_TRACK_ID    = 16'h0039;
  localparam logic [15:0] AX_MT_PRESSURE = 16'h003a;
  localparam logic [15:0] AX_DISTANCE    = 16'h003b;

  localparam logic signed [31:0] FULL_PRESSURE = 32'sd255;
  localparam logic signed [31:0] NO_TRACK      = -32'sd1;
  localparam logic [7:0]         CNT_MAX       = 8'd255;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_QUIRK = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A_DEVICE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAKE_PRESSURE  = 8'd3;

  // Op queue and result buffer sizing
  localparam int unsigned OPQ_DEPTH = 2;
  localparam int unsigned OPQ_PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int unsigned OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
  localparam int unsigned OB_DEPTH  = 2;
  localparam int unsigned OB_PTR_W  = (OB_DEPTH > 1) ? $clog2(OB_DEPTH) : 1;
  localparam int unsigned OB_CNT_W  = $clog2(OB_DEPTH + 1);

  // Decoded operations carried from front to back
  typedef enum logic [3:0] {
    OP_PEN_UP,     // mark pen lifted
    OP_REPORT,     // sync report: emit held or zero sample
    OP_MT_REPORT,  // type A contact marker
    OP_SET_X,
    OP_SET_Y,
    OP_SET_P,
    OP_SET_X_BUMP, // set x and count a contact
    OP_SET_Y_BUMP, // set y and count a contact
    OP_CLR_P,      // pressure to zero
    OP_FULL_P,     // pressure to full scale
    OP_EMIT_X,     // direct mode: set x and emit
    OP_EMIT_Y,
    OP_EMIT_P,
    OP_EMIT_HELD,
    OP_EMIT_ZERO
  } op_e;

  typedef struct packed {
    logic report_mode;
    logic distance_quirk;
    logic type_a_device;
    logic fake_pressure;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
    logic [31:0]        seconds;
    logic [19:0]        micros;
  } op_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pressure;
    logic [31:0]        seconds;
    logic [19:0]        micros;
  } res_t;

endpackage

FILE: rtl/touch_event_sample_assembler_core.sv
// Top level of the touch event sample assembler.
// Depends on tesa_pkg, tesa_front, tesa_opq and tesa_exec.
//
// Channel   Direction  Handshake                 Payload
// events    in         push / full               ev_type, ev_code, ev_value, ts_*
// samples   out        empty / pop               pos_x, pos_y, touch_pressure, out_*
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One event per cycle sustained while the result side keeps popping; a sample passes
// through the op queue and the result buffer on its way to the result ports.
// Rate is set by the op execute in tesa_exec, fed by a two-entry
// op queue and draining into a two-entry result buffer.
// Asynchronous active-low reset clears config, held state and both queues.
// A stalled result side fills the result buffer, then the op queue, then raises full.
module touch_event_sample_assembler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [15:0]                   ev_type_i,
  input  logic [15:0]                   ev_code_i,
  input  logic signed [31:0]            ev_value_i,
  input  logic [31:0]                   ts_seconds_i,
  input  logic [19:0]                   ts_micros_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic signed [31:0]            touch_pressure_o,
  output logic [31:0]                   out_seconds_o,
  output logic [19:0]                   out_micros_o,
  input  logic                          cfg_we_i,
  input  logic [tesa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                          cfg_wdata_i
);
  import tesa_pkg::*;

  cfg_t cfg;
  logic opq_full, enq, opq_valid, deq;
  op_t  enq_op, head_op;
  res_t res;

  // Front: accept and classify
  tesa_front u_front (
    .push         (push),
    .full         (full),
    .ev_type_i    (ev_type_i),
    .ev_code_i    (ev_code_i),
    .ev_value_i   (ev_value_i),
    .ts_seconds_i (ts_seconds_i),
    .ts_micros_i  (ts_micros_i),
    .cfg_i        (cfg),
    .opq_full_i   (opq_full),
    .enq_o        (enq),
    .enq_op_o     (enq_op)
  );

  // Op queue
  tesa_opq u_opq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enq_i    (enq),
    .enq_op_i (enq_op),
    .full_o   (opq_full),
    .valid_o  (opq_valid),
    .head_o   (head_op),
    .deq_i    (deq)
  );

  // Back: execute and buffer results
  tesa_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .op_valid_i  (opq_valid),
    .op_i        (head_op),
    .op_take_o   (deq),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign pos_x_o          = res.pos_x;
  assign pos_y_o          = res.pos_y;
  assign touch_pressure_o = res.pressure;
  assign out_seconds_o    = res.seconds;
  assign out_micros_o     = res.micros;

endmodule

FILE: rtl/tesa_front.sv
// Front end: accepts input events and classifies them into ops.
// Depends on tesa_pkg; feeds tesa_opq.
module tesa_front (
  input  logic                push,
  output logic                full,
  input  logic [15:0]         ev_type_i,
  input  logic [15:0]         ev_code_i,
  input  logic signed [31:0]  ev_value_i,
  input  logic [31:0]         ts_seconds_i,
  input  logic [19:0]         ts_micros_i,
  input  tesa_pkg::cfg_t      cfg_i,
  input  logic                opq_full_i,
  output logic                enq_o,
  output tesa_pkg::op_t       enq_op_o
);
  import tesa_pkg::*;

  logic keep;
  op_e  op;
  logic key_release;

  assign key_release = (ev_code_i == KEY_TOUCH || ev_code_i == KEY_LEFT) &&
                       (ev_value_i == 32'sd0);

  // Classify; items that cannot have an effect are dropped here
  always_comb begin
    keep = 1'b0;
    op   = OP_EMIT_HELD;
    if (cfg_i.report_mode) begin
      case (ev_type_i)
        EVT_KEY: begin
          keep = key_release;
          op   = OP_PEN_UP;
        end
        EVT_SYN: begin
          if (ev_code_i == SYNC_REPORT) begin
            keep = 1'b1;
            op   = OP_REPORT;
          end else if (ev_code_i == SYNC_MT_REPORT) begin
            keep = 1'b1;
            op   = OP_MT_REPORT;
          end
        end
        EVT_ABS: begin
          if (cfg_i.distance_quirk) begin
            case (ev_code_i)
              AX_X:        begin keep = 1'b1; op = OP_SET_X; end
              AX_Y:        begin keep = 1'b1; op = OP_SET_Y; end
              AX_PRESSURE: begin keep = 1'b1; op = OP_SET_P; end
              AX_DISTANCE: begin
                keep = 1'b1;
                op   = (ev_value_i > 32'sd0) ? OP_CLR_P : OP_FULL_P;
              end
              default: keep = 1'b0;
            endcase
          end else begin
            case (ev_code_i)
              AX_X:           begin keep = 1'b1; op = OP_SET_X; end
              AX_Y:           begin keep = 1'b1; op = OP_SET_Y; end
              AX_MT_X:        begin keep = 1'b1; op = OP_SET_X_BUMP; end
              AX_MT_Y:        begin keep = 1'b1; op = OP_SET_Y_BUMP; end
              AX_PRESSURE,
              AX_MT_PRESSURE: begin keep = 1'b1; op = OP_SET_P; end
              AX_TOUCH_MAJOR: begin
                keep = (ev_value_i == 32'sd0);
                op   = OP_CLR_P;
              end
              AX_TRACK_ID: begin
                keep = (ev_value_i == NO_TRACK);
                op   = OP_CLR_P;
              end
              default: keep = 1'b0;
            endcase
          end
        end
        default: keep = 1'b0;
      endcase
    end else begin
      case (ev_type_i)
        EVT_ABS: begin
          case (ev_code_i)
            AX_X: begin
              keep = (ev_value_i != 32'sd0);
              op   = OP_EMIT_X;
            end
            AX_Y: begin
              keep = (ev_value_i != 32'sd0);
              op   = OP_EMIT_Y;
            end
            AX_PRESSURE: begin keep = 1'b1; op = OP_EMIT_P; end
            default:     begin keep = 1'b1; op = OP_EMIT_HELD; end
          endcase
        end
        EVT_KEY: begin
          keep = key_release;
          op   = OP_EMIT_ZERO;
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign full  = opq_full_i;
  assign enq_o = push && !opq_full_i && keep;

  assign enq_op_o.op      = op;
  assign enq_op_o.value   = ev_value_i;
  assign enq_op_o.seconds = ts_seconds_i;
  assign enq_op_o.micros  = ts_micros_i;

endmodule

FILE: rtl/tesa_opq.sv
// Short op queue between the front end and the execution back end.
// Depends on tesa_pkg.
module tesa_opq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           enq_i,
  input  tesa_pkg::op_t  enq_op_i,
  output logic           full_o,
  output logic           valid_o,
  output tesa_pkg::op_t  head_o,
  input  logic           deq_i
);
  import tesa_pkg::*;

  op_t                  mem_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OPQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_enq, do_deq;

  assign full_o  = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_enq) begin
      wr_ptr_d = (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_deq) begin
      rd_ptr_d = (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_enq && !do_deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_enq && do_deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wr_ptr_q] <= enq_op_i;
    end
  end

endmodule

FILE: rtl/tesa_exec.sv
// Back end: configuration, held touch state, op execution, result buffer.
// Depends on tesa_pkg; takes ops from tesa_opq.
module tesa_exec (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tesa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                          cfg_wdata_i,
  output tesa_pkg::cfg_t                cfg_o,
  input  logic                          op_valid_i,
  input  tesa_pkg::op_t                 op_i,
  output logic                          op_take_o,
  output logic                          empty,
  input  logic                          pop,
  output tesa_pkg::res_t                res_o
);
  import tesa_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic signed [31:0] hx_q, hx_d, hy_q, hy_d, hp_q, hp_d;
  logic               pen_q, pen_d;
  logic [7:0]         cnt_q, cnt_d;

  res_t                ob_q [OB_DEPTH];
  logic [OB_PTR_W-1:0] ob_wr_q, ob_wr_d, ob_rd_q, ob_rd_d;
  logic [OB_CNT_W-1:0] ob_cnt_q, ob_cnt_d;

  logic pop_take, op_take, emit;
  res_t res;

  assign pop_take  = pop && !empty;
  assign empty     = (ob_cnt_q == '0);
  assign res_o     = ob_q[ob_rd_q];
  assign op_take   = op_valid_i && ((ob_cnt_q != OB_CNT_W'(OB_DEPTH)) || pop_take);
  assign op_take_o = op_take;
  assign cfg_o     = cfg_q;

  // Op execution and configuration writes
  always_comb begin
    cfg_d       = cfg_q;
    hx_d        = hx_q;
    hy_d        = hy_q;
    hp_d        = hp_q;
    pen_d       = pen_q;
    cnt_d       = cnt_q;
    emit        = 1'b0;
    res.pos_x    = hx_q;
    res.pos_y    = hy_q;
    res.pressure = hp_q;
    res.seconds  = op_i.seconds;
    res.micros   = op_i.micros;

    if (op_take) begin
      case (op_i.op)
        OP_PEN_UP: pen_d = 1'b1;
        OP_REPORT: begin
          emit = 1'b1;
          if (pen_q) begin
            pen_d        = 1'b0;
            res.pos_x    = '0;
            res.pos_y    = '0;
            res.pressure = '0;
          end
        end
        OP_MT_REPORT: begin
          if (cnt_q == 8'd1) begin
            pen_d = 1'b1;
          end else if (cnt_q != 8'd0) begin
            cnt_d = 8'd1;
          end
        end
        OP_SET_X: hx_d = op_i.value;
        OP_SET_Y: hy_d = op_i.value;
        OP_SET_P: hp_d = op_i.value;
        OP_SET_X_BUMP: begin
          hx_d = op_i.value;
          if (cnt_q != CNT_MAX) cnt_d = cnt_q + 8'd1;
        end
        OP_SET_Y_BUMP: begin
          hy_d = op_i.value;
          if (cnt_q != CNT_MAX) cnt_d = cnt_q + 8'd1;
        end
        OP_CLR_P:  hp_d = '0;
        OP_FULL_P: hp_d = FULL_PRESSURE;
        OP_EMIT_X: begin
          emit      = 1'b1;
          hx_d      = op_i.value;
          res.pos_x = op_i.value;
        end
        OP_EMIT_Y: begin
          emit      = 1'b1;
          hy_d      = op_i.value;
          res.pos_y = op_i.value;
        end
        OP_EMIT_P: begin
          emit         = 1'b1;
          hp_d         = op_i.value;
          res.pressure = op_i.value;
        end
        OP_EMIT_HELD: emit = 1'b1;
        OP_EMIT_ZERO: begin
          emit         = 1'b1;
          res.pos_x    = '0;
          res.pos_y    = '0;
          res.pressure = '0;
        end
        default: emit = 1'b0;
      endcase
      // fake pressure: restore full scale after each sample
      if (emit && cfg_q.fake_pressure) begin
        hp_d = FULL_PRESSURE;
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REPORT_MODE:    cfg_d.report_mode    = cfg_wdata_i;
        CFG_DISTANCE_QUIRK: cfg_d.distance_quirk = cfg_wdata_i;
        CFG_TYPE_A_DEVICE: begin
          cfg_d.type_a_device = cfg_wdata_i;
          cnt_d               = {7'd0, cfg_wdata_i};
        end
        CFG_FAKE_PRESSURE: begin
          cfg_d.fake_pressure = cfg_wdata_i;
          if (cfg_wdata_i) hp_d = FULL_PRESSURE;
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Result buffer pointers
  always_comb begin
    ob_wr_d  = ob_wr_q;
    ob_rd_d  = ob_rd_q;
    ob_cnt_d = ob_cnt_q;
    if (emit) begin
      ob_wr_d = (ob_wr_q == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_wr_q + 1'b1;
    end
    if (pop_take) begin
      ob_rd_d = (ob_rd_q == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_rd_q + 1'b1;
    end
    if (emit && !pop_take) begin
      ob_cnt_d = ob_cnt_q + 1'b1;
    end else if (!emit && pop_take) begin
      ob_cnt_d = ob_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '0;
      hx_q     <= '0;
      hy_q     <= '0;
      hp_q     <= '0;
      pen_q    <= 1'b0;
      cnt_q    <= '0;
      ob_wr_q  <= '0;
      ob_rd_q  <= '0;
      ob_cnt_q <= '0;
    end else begin
      cfg_q    <= cfg_d;
      hx_q     <= hx_d;
      hy_q     <= hy_d;
      hp_q     <= hp_d;
      pen_q    <= pen_d;
      cnt_q    <= cnt_d;
      ob_wr_q  <= ob_wr_d;
      ob_rd_q  <= ob_rd_d;
      ob_cnt_q <= ob_cnt_d;
    end
  end

  // Result storage, no reset
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_q[ob_wr_q] <= res;
    end
  end

  // Buffer never overfills
  a_ob_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q <= OB_CNT_W'(OB_DEPTH))
    else $error("result buffer overfilled");

  // A sample with no concurrent pop grows the buffer by one
  a_ob_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !pop_take) |=> (ob_cnt_q == $past(ob_cnt_q) + 1'b1))
    else $error("emitted sample not stored");

  // Fake pressure restores full scale after a sample
  a_fake_restore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cfg_q.fake_pressure) |=> (hp_q == FULL_PRESSURE))
    else $error("pressure not restored after sample");

  // A pen-up report clears the lifted flag
  a_pen_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_take && op_i.op == OP_REPORT && pen_q) |=> !pen_q)
    else $error("pen-up flag not cleared by report");

endmodule

FILE: tb/sv/touch_event_sample_assembler_core_tb.sv
// Self-checking testbench for touch_event_sample_assembler_core.
// Drives event items through the push/full queue port and checks each popped sample
// against a local model of the assembler. Depends on tesa_pkg and the core RTL.
`timescale 1ns / 100ps

module touch_event_sample_assembler_core_tb;
  import tesa_pkg::*;

  // One input event as the controller link delivers it
  typedef struct {
    logic [15:0]        kind;
    logic [15:0]        code;
    logic signed [31:0] value;
    logic [31:0]        sec;
    logic [19:0]        usec;
  } touch_event_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [15:0]           ev_type_i = '0;
  logic [15:0]           ev_code_i = '0;
  logic signed [31:0]    ev_value_i = '0;
  logic [31:0]           ts_seconds_i = '0;
  logic [19:0]           ts_micros_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic signed [31:0]    pos_x_o;
  logic signed [31:0]    pos_y_o;
  logic signed [31:0]    touch_pressure_o;
  logic [31:0]           out_seconds_o;
  logic [19:0]           out_micros_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic                  cfg_wdata_i = 1'b0;

  // Tracked assembler state and register copy
  cfg_t               mode_cfg;
  logic signed [31:0] trk_x;
  logic signed [31:0] trk_y;
  logic signed [31:0] trk_p;
  logic               trk_lifted;
  logic [7:0]         trk_contacts;

  res_t pending_samples[$];
  int   events_sent = 0;
  int   samples_seen = 0;
  int   settings_used = 0;
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  touch_event_sample_assembler_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .ev_type_i        (ev_type_i),
    .ev_code_i        (ev_code_i),
    .ev_value_i       (ev_value_i),
    .ts_seconds_i     (ts_seconds_i),
    .ts_micros_i      (ts_micros_i),
    .empty            (empty),
    .pop              (pop),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .touch_pressure_o (touch_pressure_o),
    .out_seconds_o    (out_seconds_o),
    .out_micros_o     (out_micros_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Sample model
  // ---------------------------------------------------------------------------

  function automatic res_t sample_of(input logic signed [31:0] x, input logic signed [31:0] y,
                                     input logic signed [31:0] p, input touch_event_t ev);
    res_t s;
    s.pos_x    = x;
    s.pos_y    = y;
    s.pressure = p;
    s.seconds  = ev.sec;
    s.micros   = ev.usec;
    return s;
  endfunction

  function automatic bit is_release(input touch_event_t ev);
    return (ev.code == KEY_TOUCH || ev.code == KEY_LEFT) && ev.value == 0;
  endfunction

  // Update tracked state for one accepted event; queue the sample it yields
  task automatic assemble_sample(input touch_event_t ev);
    res_t s;
    bit   hit;
    hit = 1'b0;
    if (mode_cfg.report_mode) begin
      case (ev.kind)
        EVT_KEY: if (is_release(ev)) trk_lifted = 1'b1;
        EVT_SYN: begin
          if (ev.code == SYNC_REPORT) begin
            hit = 1'b1;
            if (trk_lifted) begin
              trk_lifted = 1'b0;
              s = sample_of(0, 0, 0, ev);
            end else begin
              s = sample_of(trk_x, trk_y, trk_p, ev);
            end
          end else if (ev.code == SYNC_MT_REPORT && trk_contacts != 0) begin
            // single contact left: marker means lift; otherwise fold back to one
            if (trk_contacts == 8'd1) trk_lifted = 1'b1;
            else trk_contacts = 8'd1;
          end
        end
        EVT_ABS: begin
          if (mode_cfg.distance_quirk) begin
            case (ev.code)
              AX_X:        trk_x = ev.value;
              AX_Y:        trk_y = ev.value;
              AX_PRESSURE: trk_p = ev.value;
              AX_DISTANCE: trk_p = (ev.value > 0) ? 32'sd0 : FULL_PRESSURE;
              default: ;
            endcase
          end else begin
            case (ev.code)
              AX_X: trk_x = ev.value;
              AX_Y: trk_y = ev.value;
              AX_MT_X: begin
                trk_x = ev.value;
                if (trk_contacts != CNT_MAX) trk_contacts++;
              end
              AX_MT_Y: begin
                trk_y = ev.value;
                if (trk_contacts != CNT_MAX) trk_contacts++;
              end
              AX_PRESSURE, AX_MT_PRESSURE: trk_p = ev.value;
              AX_TOUCH_MAJOR: if (ev.value == 0) trk_p = 0;
              AX_TRACK_ID:    if (ev.value == NO_TRACK) trk_p = 0;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end else begin
      // direct mode: axis events emit at once, zero x or y is dropped
      if (ev.kind == EVT_ABS) begin
        hit = 1'b1;
        if (ev.code == AX_X) begin
          if (ev.value == 0) hit = 1'b0;
          else trk_x = ev.value;
        end else if (ev.code == AX_Y) begin
          if (ev.value == 0) hit = 1'b0;
          else trk_y = ev.value;
        end else if (ev.code == AX_PRESSURE) begin
          trk_p = ev.value;
        end
        if (hit) s = sample_of(trk_x, trk_y, trk_p, ev);
      end else if (ev.kind == EVT_KEY && is_release(ev)) begin
        hit = 1'b1;
        s = sample_of(0, 0, 0, ev);
      end
    end
    if (hit) begin
      pending_samples.push_back(s);
      if (mode_cfg.fake_pressure) trk_p = FULL_PRESSURE;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sample side: random pop, compare each popped sample
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : sample_check
    res_t want;
    if (pop && !empty) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected sample, expected none, actual x=%0d y=%0d p=%0d",
                 $time, pos_x_o, pos_y_o, touch_pressure_o);
      end else begin
        want = pending_samples.pop_front();
        check_field("pos_x", want.pos_x, pos_x_o);
        check_field("pos_y", want.pos_y, pos_y_o);
        check_field("touch_pressure", want.pressure, touch_pressure_o);
        check_field("out_seconds", want.seconds, out_seconds_o);
        check_field("out_micros", {12'd0, want.micros}, {12'd0, out_micros_o});
        samples_seen++;
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Event side
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      2, 3: v = $urandom();
      default: v = $urandom_range(0, 4095);
    endcase
    return v;
  endfunction

  function automatic touch_event_t mk_ev(input logic [15:0] kind, input logic [15:0] code,
                                         input logic signed [31:0] value);
    touch_event_t ev;
    ev.kind  = kind;
    ev.code  = code;
    ev.value = value;
    ev.sec   = $urandom();
    ev.usec  = 20'($urandom_range(0, 999999));
    return ev;
  endfunction

  // Push one item, hold until accepted, then update the model
  task automatic send_event(input touch_event_t ev);
    // idle cycle by cycle at the sender's idle rate
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    ev_type_i    <= ev.kind;
    ev_code_i    <= ev.code;
    ev_value_i   <= ev.value;
    ts_seconds_i <= ev.sec;
    ts_micros_i  <= ev.usec;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    assemble_sample(ev);
    events_sent++;
  endtask

  // Stop sending and wait until every pending sample has been popped
  task automatic quiesce();
    push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    // events that yield no sample may still sit in the op queue
    repeat (6) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------

  function automatic cfg_t cfg_of(input bit rep, input bit quirk, input bit type_a, input bit fake);
    cfg_t c;
    c.report_mode    = rep;
    c.distance_quirk = quirk;
    c.type_a_device  = type_a;
    c.fake_pressure  = fake;
    return c;
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic bit_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= bit_val;
    @(posedge clk_i);
    case (idx)
      CFG_REPORT_MODE:    mode_cfg.report_mode = bit_val;
      CFG_DISTANCE_QUIRK: mode_cfg.distance_quirk = bit_val;
      CFG_TYPE_A_DEVICE: begin
        mode_cfg.type_a_device = bit_val;
        trk_contacts = {7'd0, bit_val};
      end
      CFG_FAKE_PRESSURE: begin
        mode_cfg.fake_pressure = bit_val;
        if (bit_val) trk_p = FULL_PRESSURE;
      end
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    quiesce();
    write_reg(CFG_REPORT_MODE, c.report_mode);
    write_reg(CFG_DISTANCE_QUIRK, c.distance_quirk);
    write_reg(CFG_TYPE_A_DEVICE, c.type_a_device);
    write_reg(CFG_FAKE_PRESSURE, c.fake_pressure);
    // index past the register list must be ignored
    write_reg(CFG_IDX_W'($urandom_range(CFG_FAKE_PRESSURE + 1, 255)),
              1'($urandom_range(0, 1)));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] rand_code();
    logic [15:0] c;
    case ($urandom_range(0, 12))
      0:  c = AX_X;
      1:  c = AX_Y;
      2:  c = AX_PRESSURE;
      3:  c = AX_TOUCH_MAJOR;
      4:  c = AX_MT_X;
      5:  c = AX_MT_Y;
      6:  c = AX_TRACK_ID;
      7:  c = AX_MT_PRESSURE;
      8:  c = AX_DISTANCE;
      9:  c = KEY_TOUCH;
      10: c = KEY_LEFT;
      11: c = SYNC_MT_REPORT;
      default: c = 16'($urandom());
    endcase
    return c;
  endfunction

  function automatic touch_event_t rand_noise();
    touch_event_t ev;
    logic [15:0]  kind;
    case ($urandom_range(0, 3))
      0: kind = EVT_SYN;
      1: kind = EVT_KEY;
      2: kind = EVT_ABS;
      default: kind = 16'($urandom());
    endcase
    ev = mk_ev(kind, rand_code(), rand_value());
    // full 20-bit microseconds, out-of-range values included
    ev.usec = 20'($urandom_range(0, 20'hfffff));
    return ev;
  endfunction

  // One mostly well-formed report sequence with random content
  task automatic send_random_burst();
    int          pick;
    int          n;
    logic [15:0] key;
    pick = $urandom_range(0, 99);
    key  = $urandom_range(0, 1) ? KEY_TOUCH : KEY_LEFT;
    if (pick < 40) begin
      // single-touch frame
      if ($urandom_range(0, 3) == 0) send_event(mk_ev(EVT_KEY, key, 1));
      if ($urandom_range(0, 3) != 0) send_event(mk_ev(EVT_ABS, AX_X, rand_value()));
      if ($urandom_range(0, 3) != 0) send_event(mk_ev(EVT_ABS, AX_Y, rand_value()));
      if ($urandom_range(0, 1) != 0) send_event(mk_ev(EVT_ABS, AX_PRESSURE, rand_value()));
      if ($urandom_range(0, 5) == 0) send_event(mk_ev(EVT_KEY, key, 0));
      send_event(mk_ev(EVT_SYN, SYNC_REPORT, rand_value()));
    end else if (pick < 65) begin
      // type A frame with one or two contacts
      n = $urandom_range(1, 2);
      repeat (n) begin
        send_event(mk_ev(EVT_ABS, AX_MT_X, rand_value()));
        send_event(mk_ev(EVT_ABS, AX_MT_Y, rand_value()));
        case ($urandom_range(0, 2))
          0: send_event(mk_ev(EVT_ABS, AX_MT_PRESSURE, rand_value()));
          1: send_event(mk_ev(EVT_ABS, AX_TOUCH_MAJOR, $urandom_range(0, 1) ? 0 : rand_value()));
          default: send_event(mk_ev(EVT_ABS, AX_TRACK_ID, $urandom_range(0, 1) ? -1 : rand_value()));
        endcase
        send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, rand_value()));
      end
      if ($urandom_range(0, 3) == 0) send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, 0));
      send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    end else if (pick < 78) begin
      // lift by each of the possible routes
      case ($urandom_range(0, 3))
        0: send_event(mk_ev(EVT_KEY, key, 0));
        1: send_event(mk_ev(EVT_ABS, AX_TOUCH_MAJOR, 0));
        2: send_event(mk_ev(EVT_ABS, AX_TRACK_ID, -1));
        default: send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, 0));
      endcase
      send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    end else if (pick < 88) begin
      // hover distance
      send_event(mk_ev(EVT_ABS, AX_DISTANCE, rand_value()));
      if ($urandom_range(0, 1) != 0) send_event(mk_ev(EVT_ABS, AX_PRESSURE, rand_value()));
      send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    end else begin
      send_event(rand_noise());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Per-axis emission, dropped zero coordinates, key release, extremes
  task automatic test_direct_mode();
    touch_event_t ev;
    apply_config(cfg_of(0, 0, 0, 0));
    send_event(mk_ev(EVT_ABS, AX_X, 0));
    send_event(mk_ev(EVT_ABS, AX_X, 32'sh7fffffff));
    send_event(mk_ev(EVT_ABS, AX_Y, 32'sh80000000));
    send_event(mk_ev(EVT_ABS, AX_Y, 0));
    send_event(mk_ev(EVT_ABS, AX_PRESSURE, -1));
    send_event(mk_ev(EVT_ABS, AX_TOUCH_MAJOR, 7));
    send_event(mk_ev(EVT_KEY, KEY_TOUCH, 1));
    ev = mk_ev(EVT_KEY, KEY_TOUCH, 0);
    ev.sec  = '1;
    ev.usec = '1;
    send_event(ev);
    ev = mk_ev(EVT_KEY, KEY_LEFT, 0);
    ev.sec  = '0;
    ev.usec = '0;
    send_event(ev);
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    send_event(mk_ev(16'hffff, 16'hffff, $urandom()));
  endtask

  // Held values on sync report, zero sample after a release
  task automatic test_report_mode();
    apply_config(cfg_of(1, 0, 0, 0));
    send_event(mk_ev(EVT_ABS, AX_X, 100));
    send_event(mk_ev(EVT_ABS, AX_Y, 200));
    send_event(mk_ev(EVT_ABS, AX_MT_PRESSURE, 50));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    // marker with no contacts counted is ignored
    send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, 0));
    send_event(mk_ev(EVT_KEY, KEY_LEFT, 0));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    send_event(mk_ev(EVT_ABS, AX_TRACK_ID, -1));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
  endtask

  // Type A markers: fold back to one contact, then lift; fake pressure on
  task automatic test_type_a_markers();
    apply_config(cfg_of(1, 0, 1, 1));
    send_event(mk_ev(EVT_ABS, AX_MT_X, 5));
    send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, 0));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, 0));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
  endtask

  // Distance maps to pressure; multitouch coordinates ignored
  task automatic test_distance_quirk();
    apply_config(cfg_of(1, 1, 0, 0));
    send_event(mk_ev(EVT_ABS, AX_DISTANCE, 9));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    send_event(mk_ev(EVT_ABS, AX_DISTANCE, 0));
    send_event(mk_ev(EVT_ABS, AX_MT_X, 77));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
  endtask

  // Long run of contact coordinates: the counter must stop at its maximum
  task automatic test_contact_saturation();
    apply_config(cfg_of(1, 0, 1, 0));
    repeat (150) begin
      send_event(mk_ev(EVT_ABS, AX_MT_X, rand_value()));
      send_event(mk_ev(EVT_ABS, AX_MT_Y, rand_value()));
    end
    send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, 0));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
    send_event(mk_ev(EVT_SYN, SYNC_MT_REPORT, 0));
    send_event(mk_ev(EVT_SYN, SYNC_REPORT, 0));
  endtask

  // Random sequences over six register settings, extremes first
  task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
    cfg_t c;
    int   target;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 0) begin
        c = '0;
      end else if (seg == 1) begin
        c = '1;
      end else begin
        c = cfg_of(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      apply_config(c);
      target = events_sent + n_items / 6;
      while (events_sent < target) begin
        send_random_burst();
        // late in the fourth segment, now and then hold off until the sample queue runs dry
        if (seg == 3 && events_sent >= target - n_items / 12 && $urandom_range(0, 7) == 0)
          quiesce();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    mode_cfg     = '0;
    trk_x        = 0;
    trk_y        = 0;
    trk_p        = 0;
    trk_lifted   = 1'b0;
    trk_contacts = 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 10;
    recv_idle_pct = 46;
    test_direct_mode();
    test_report_mode();
    test_type_a_markers();
    test_distance_quirk();
    test_contact_saturation();

    test_random_traffic(380, 10, 46);
    test_random_traffic(380, 46, 10);
    test_random_traffic(380, 0, 0);

    quiesce();
    $display("Covered %0d events over %0d register settings and three idle profiles;",
             events_sent, settings_used);
    $display("%0d samples compared field by field.", samples_seen);
    if (mismatch_count == 0)
      $display("touch_event_sample_assembler_core_tb OK");
    else
      $display("touch_event_sample_assembler_core_tb NOT OK");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t ns: timeout with %0d samples pending", $time, pending_samples.size());
    $display("touch_event_sample_assembler_core_tb NOT OK");
    $finish;
  end

endmodule
